FILE: sv/ied_pkg.sv
`timescale 1ns / 1ps

package ied_pkg;

   // Field widths of the streamed pairs and of the result.
   localparam int ELEM_W  = 8;
   localparam int DIFF_W  = ELEM_W + 1;
   localparam int SQ_W    = 2 * ELEM_W + 1;
   localparam int SUM_W   = 26;
   localparam int FRAC_W  = 8;
   localparam int DIST_W  = 21;

   // The radicand is the sum scaled by 2^(2*FRAC_W); one root bit per step.
   localparam int RAD_W   = SUM_W + 2 * FRAC_W;
   localparam int STEPS   = RAD_W / 2;
   localparam int STEP_W  = $clog2(STEPS);
   localparam int REM_W   = DIST_W + 3;

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // One finished vector waiting for its square root.
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic             saturated;
   } qent_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

FILE: sv/ied_front.sv
`timescale 1ns / 1ps

module ied_front #(
   parameter int MAX_LEN = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [ied_pkg::ELEM_W-1:0]  req_elem_a,
   input  logic signed [ied_pkg::ELEM_W-1:0]  req_elem_b,
   input  logic                               req_last,
   input  ied_pkg::qstat_type                 q_stat,
   output logic                               q_push,
   output ied_pkg::qent_type                  q_data
);
   import ied_pkg::*;

   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN);

   logic [SUM_W-1:0] square_sum_ff, square_sum_in;
   logic [CNT_W-1:0] pair_count_ff, pair_count_in;
   logic             overflow_ff, overflow_in;

   logic                     accept;
   logic signed [DIFF_W-1:0] diff;
   logic signed [2*DIFF_W-1:0] sq_full;
   logic [SUM_W:0]           sum_add;
   logic [SUM_W-1:0]         sum_upd;
   logic                     ovf_upd;
   logic [CNT_W-1:0]         cnt_upd;

   // A pair is taken whenever the queue has room for a possible result.
   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   // Squared difference of one pair and the saturating running sum.
   always_comb begin
      diff    = DIFF_W'(req_elem_a) - DIFF_W'(req_elem_b);
      sq_full = diff * diff;
      sum_add = {1'b0, square_sum_ff} + (SUM_W + 1)'(sq_full[SQ_W-1:0]);
      if (pair_count_ff >= CNT_LIMIT) begin
         sum_upd = SUM_MAX;
         ovf_upd = 1'b1;
         cnt_upd = pair_count_ff;
      end else begin
         cnt_upd = pair_count_ff + CNT_W'(1);
         if (sum_add[SUM_W]) begin
            sum_upd = SUM_MAX;
            ovf_upd = 1'b1;
         end else begin
            sum_upd = sum_add[SUM_W-1:0];
            ovf_upd = overflow_ff;
         end
      end
   end

   // The last pair hands the finished sum to the queue and clears the state.
   assign q_push         = accept && req_last;
   assign q_data.sum       = sum_upd;
   assign q_data.saturated = ovf_upd;

   always_comb begin
      square_sum_in = square_sum_ff;
      pair_count_in = pair_count_ff;
      overflow_in   = overflow_ff;
      if (accept) begin
         if (req_last) begin
            square_sum_in = '0;
            pair_count_in = '0;
            overflow_in   = 1'b0;
         end else begin
            square_sum_in = sum_upd;
            pair_count_in = cnt_upd;
            overflow_in   = ovf_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_sum_ff <= '0;
         pair_count_ff <= '0;
         overflow_ff   <= 1'b0;
      end else begin
         square_sum_ff <= square_sum_in;
         pair_count_ff <= pair_count_in;
         overflow_ff   <= overflow_in;
      end
   end

   // The count never passes the vector length limit.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pair_count_ff <= CNT_LIMIT)
      else $error("pair count above limit");

   // A saturated sum is always flagged.
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      (pair_count_ff >= CNT_LIMIT && accept) |=> (overflow_ff || $past(req_last)))
      else $error("overflow not flagged");

   // Nothing is pushed into a full queue.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !q_push)
      else $error("push into full queue");

endmodule

FILE: sv/ied_queue.sv
`timescale 1ns / 1ps

module ied_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ied_pkg::qent_type  push_data,
   input  logic               pop,
   output ied_pkg::qent_type  head,
   output ied_pkg::qstat_type stat
);
   import ied_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   qent_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;

   assign stat.full  = (count_ff == (PTR_W + 1)'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   // Pointer and fill-count update for one push and one pop per cycle.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage of the queued sums.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The fill count stays within the depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W + 1)'(DEPTH))
      else $error("queue count out of range");

   // The pointers stay consistent with the fill count.
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (PTR_W)'(rd_ptr_ff + count_ff[PTR_W-1:0]) == wr_ptr_ff)
      else $error("queue pointers disagree with count");

   // Nothing is taken from an empty queue.
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      stat.empty |-> !pop)
      else $error("pop from empty queue");

endmodule

FILE: sv/ied_sqrt.sv
`timescale 1ns / 1ps

module ied_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  ied_pkg::qstat_type            q_stat,
   input  ied_pkg::qent_type             q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ied_pkg::DIST_W-1:0]    rsp_distance_q8,
   output logic                          rsp_saturated
);
   import ied_pkg::*;

   typedef enum logic [2:0] {
      IDLE = 3'b001,
      BUSY = 3'b010,
      DONE = 3'b100
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIST_W-1:0] root_ff, root_in;
   logic              sat_ff, sat_in;

   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;

   // One restoring step: bring down two radicand bits and try a root bit of one.
   assign rem_shift = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial     = REM_W'({root_ff, 2'b01});

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      sat_in   = sat_ff;
      q_pop    = 1'b0;
      case (state_ff)
         IDLE: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               rad_in   = {q_head.sum, (2 * FRAC_W)'(0)};
               sat_in   = q_head.saturated;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = BUSY;
            end
         end
         BUSY: begin
            rad_in = {rad_ff[RAD_W-3:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[DIST_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[DIST_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (!rsp_stall) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      sat_ff  <= sat_in;
   end

   // The finished root is held in place until the result transfer.
   assign rsp_valid       = (state_ff == DONE);
   assign rsp_distance_q8 = root_ff;
   assign rsp_saturated   = sat_ff;

   // A restoring remainder never exceeds twice the partial root.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BUSY) |-> (rem_ff <= REM_W'({root_ff, 1'b0})))
      else $error("square root remainder out of range");

   // The step counter stays within the number of root bits.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BUSY) |-> (step_ff <= STEP_W'(STEPS - 1)))
      else $error("square root step out of range");

   // A new vector is taken only from a queue that holds one.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!q_stat.empty && state_ff == IDLE))
      else $error("square root started without data");

endmodule

FILE: sv/int8_vector_euclidean_distance.sv
`timescale 1ns / 1ps

// Streams paired signed 8-bit elements, one pair per cycle while req_stall
// is low, and on the pair marked last returns floor(sqrt(sum of squared
// differences) * 256) with a flag that is set when more than MAX_LEN pairs
// came in or the 26-bit sum overflowed; either saturates the sum. The front
// accumulates at one pair per clock while the queue is not full; each
// finished sum goes into a two-entry queue, and the square-root unit then
// takes each vector through a load, 21 restoring steps of one root bit
// each, and the result transfer. Vectors of 23 or more pairs therefore
// stream at full rate while results are taken at once; shorter ones can
// fill the queue, and the input stalls until the root unit frees an entry.
module int8_vector_euclidean_distance #(
   parameter int MAX_LEN = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ied_pkg::ELEM_W-1:0] req_elem_a,
   input  logic signed [ied_pkg::ELEM_W-1:0] req_elem_b,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ied_pkg::DIST_W-1:0]        rsp_distance_q8,
   output logic                              rsp_saturated
);
   import ied_pkg::*;

   qstat_type q_stat;
   qent_type  q_in;
   qent_type  q_head;
   logic      q_push;
   logic      q_pop;

   // Accumulation front end.
   ied_front #(
      .MAX_LEN (MAX_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_elem_a (req_elem_a),
      .req_elem_b (req_elem_b),
      .req_last   (req_last),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_data     (q_in)
   );

   // Finished sums waiting for the root unit.
   ied_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   // Bit-serial square root and result register.
   ied_sqrt u_sqrt (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_distance_q8 (rsp_distance_q8),
      .rsp_saturated   (rsp_saturated)
   );

endmodule

FILE: tb/distance_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the distance block. Every accepted pair updates a
// private model of the running sum, and a pair marked last queues the
// distance it should produce. Every result transfer is compared with the
// oldest queued distance.
module distance_checker #(
   parameter int MAX_LEN = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic signed [ied_pkg::ELEM_W-1:0] req_elem_a,
   input  logic signed [ied_pkg::ELEM_W-1:0] req_elem_b,
   input  logic                              req_last,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [ied_pkg::DIST_W-1:0]        rsp_distance_q8,
   input  logic                              rsp_saturated,
   output int                                fail_count,
   output int                                pending_count
);

   import ied_pkg::*;

   typedef struct packed {
      logic [DIST_W-1:0] distance_q8;
      logic              saturated;
   } distance_result_type;

   // Running state of the vector pair being streamed.
   logic [SUM_W-1:0] sq_sum = '0;
   int               pair_total = 0;
   logic             sum_saturated = 1'b0;

   distance_result_type expected_distances[$];
   distance_result_type oldest;
   int                  mismatches = 0;
   int                  diff;
   longint              total;

   // Truncated square root of the sum scaled by 2^16, one root bit at a time
   // from the top down.
   function automatic logic [DIST_W-1:0] root_q8(input logic [SUM_W-1:0] sum);
      logic [63:0]       radicand;
      logic [63:0]       trial;
      logic [DIST_W-1:0] root;
      radicand = 64'(sum) << (2 * FRAC_W);
      root = '0;
      for (int i = DIST_W - 1; i >= 0; i--) begin
         trial = 64'(root) | (64'd1 << i);
         if (trial * trial <= radicand) begin
            root = trial[DIST_W-1:0];
         end
      end
      return root;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         // Compare first, so that a result never meets the expectation that
         // a pair in the same cycle has just queued.
         if (rsp_valid && !rsp_stall) begin
            if (expected_distances.size() == 0) begin
               $display("%0t: result transfer with none expected, actual distance %0d sat %0d",
                        $time, rsp_distance_q8, rsp_saturated);
               mismatches++;
            end else begin
               oldest = expected_distances.pop_front();
               if (rsp_distance_q8 !== oldest.distance_q8) begin
                  $display("%0t: distance_q8 mismatch, expected %0d, actual %0d",
                           $time, oldest.distance_q8, rsp_distance_q8);
                  mismatches++;
               end
               if (rsp_saturated !== oldest.saturated) begin
                  $display("%0t: saturated mismatch, expected %0d, actual %0d",
                           $time, oldest.saturated, rsp_saturated);
                  mismatches++;
               end
            end
         end

         // Accumulate the squared difference of each accepted pair.
         if (req_valid && !req_stall) begin
            diff = int'(req_elem_a) - int'(req_elem_b);
            if (pair_total >= MAX_LEN) begin
               sq_sum = SUM_MAX;
               sum_saturated = 1'b1;
            end else begin
               pair_total++;
               total = longint'(sq_sum) + longint'(diff * diff);
               if (total > longint'(SUM_MAX)) begin
                  sq_sum = SUM_MAX;
                  sum_saturated = 1'b1;
               end else begin
                  sq_sum = total[SUM_W-1:0];
               end
            end
            if (req_last) begin
               expected_distances.push_back('{root_q8(sq_sum), sum_saturated});
               sq_sum = '0;
               pair_total = 0;
               sum_saturated = 1'b0;
            end
         end
      end
      fail_count <= mismatches;
      pending_count <= expected_distances.size();
   end

endmodule

FILE: tb/tb_int8_vector_euclidean_distance.sv
`timescale 1ns / 1ps

module tb_int8_vector_euclidean_distance;

   import ied_pkg::*;

   localparam int MAX_LEN      = 1024;
   localparam int RANDOM_PAIRS = 470;
   localparam int WIDE_LEN     = 8;
   localparam int LONG_HOLD    = 400;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic signed [ELEM_W-1:0] req_elem_a = '0;
   logic signed [ELEM_W-1:0] req_elem_b = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [DIST_W-1:0]        rsp_distance_q8;
   logic                     rsp_saturated;

   int fail_count;
   int pending_count;
   int quiet_cycles = 0;

   // Idling controls shared by the sender and the receiver.
   bit source_gaps = 1'b1;
   bit sink_stalls = 1'b1;
   bit hold_pending = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   int8_vector_euclidean_distance #(
      .MAX_LEN(MAX_LEN)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elem_a     (req_elem_a),
      .req_elem_b     (req_elem_b),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_distance_q8(rsp_distance_q8),
      .rsp_saturated  (rsp_saturated)
   );

   distance_checker #(
      .MAX_LEN(MAX_LEN)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_elem_a     (req_elem_a),
      .req_elem_b     (req_elem_b),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_distance_q8(rsp_distance_q8),
      .rsp_saturated  (rsp_saturated),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // Offers one pair after an optional gap and waits for its transfer.
   task automatic offer_pair(input logic signed [ELEM_W-1:0] a,
                             input logic signed [ELEM_W-1:0] b,
                             input logic last);
      int gap;
      gap = source_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_elem_a <= a;
      req_elem_b <= b;
      req_last <= last;
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly random bytes, with the two extremes drawn often.
   function automatic logic signed [ELEM_W-1:0] pick_element();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) begin
         return 8'sh80;
      end else if (r == 1) begin
         return 8'sh7f;
      end
      return ELEM_W'($urandom);
   endfunction

   // Streams one vector pair; the widest difference is used when asked.
   task automatic send_vector(input int len, input bit widest);
      for (int i = 0; i < len; i++) begin
         if (widest) begin
            offer_pair(8'sh7f, 8'sh80, i == len - 1);
         end else begin
            offer_pair(pick_element(), pick_element(), i == len - 1);
         end
      end
   endtask

   // Receiver: a random hold-off before each result, or one long hold when
   // the sender asks for back pressure.
   initial begin
      int stall_cycles;
      @(negedge reset);
      forever begin
         if (hold_pending) begin
            stall_cycles = LONG_HOLD;
            hold_pending = 1'b0;
         end else begin
            stall_cycles = sink_stalls ? $urandom_range(0, 4) : 0;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_int8_vector_euclidean_distance failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int  random_pairs;
      int  len;
      int  r;
      bit  pressure_done;
      random_pairs = 0;
      pressure_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed pairs: extremes, equal elements, single pairs and short vectors.
      source_gaps = 1'b0;
      sink_stalls = 1'b0;
      offer_pair(8'sh7f, 8'sh80, 1'b1);
      offer_pair(8'sh80, 8'sh7f, 1'b1);
      offer_pair(8'sh00, 8'sh00, 1'b1);
      offer_pair(8'sh80, 8'sh80, 1'b1);
      offer_pair(8'sh7f, 8'sh7f, 1'b1);
      offer_pair(8'shff, 8'sh00, 1'b1);
      offer_pair(8'sh01, 8'sh00, 1'b0);
      offer_pair(8'sh01, 8'sh00, 1'b0);
      offer_pair(8'sh01, 8'sh00, 1'b1);
      offer_pair(8'sh80, 8'sh7f, 1'b0);
      offer_pair(8'sh80, 8'sh7f, 1'b0);
      offer_pair(8'sh80, 8'sh7f, 1'b0);
      offer_pair(8'sh7f, 8'sh80, 1'b1);
      offer_pair(8'sh55, 8'shaa, 1'b0);
      offer_pair(8'shaa, 8'sh55, 1'b1);
      offer_pair(8'sh02, 8'sh00, 1'b0);
      offer_pair(8'sh00, 8'sh02, 1'b1);
      source_gaps = 1'b1;
      sink_stalls = 1'b1;
      offer_pair(8'sh33, 8'shcc, 1'b1);
      offer_pair(8'shf0, 8'sh0f, 1'b1);

      // A short vector with the widest difference on every pair.
      send_vector(WIDE_LEN, 1'b1);

      // Random vectors, mostly short so that results come often.
      while (random_pairs < RANDOM_PAIRS) begin
         if ($urandom_range(0, 15) == 0) begin
            source_gaps = $urandom_range(0, 2) != 0;
            sink_stalls = $urandom_range(0, 2) != 0;
         end
         if (!pressure_done && random_pairs >= RANDOM_PAIRS / 2) begin
            // Hold the result side while short vectors keep coming.
            pressure_done = 1'b1;
            source_gaps = 1'b0;
            hold_pending = 1'b1;
            for (int v = 0; v < 24; v++) begin
               len = $urandom_range(1, 2);
               send_vector(len, 1'b0);
               random_pairs += len;
            end
            source_gaps = 1'b1;
         end
         r = $urandom_range(0, 9);
         if (r < 5) begin
            len = $urandom_range(1, 3);
         end else if (r < 8) begin
            len = $urandom_range(4, 30);
         end else begin
            len = $urandom_range(31, 64);
         end
         send_vector(len, 1'b0);
         random_pairs += len;
      end
      req_valid <= 1'b0;

      // Wait for the outstanding distances, then watch for stray results.
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_int8_vector_euclidean_distance passed");
      end else begin
         $display("tb_int8_vector_euclidean_distance failed");
      end
      $finish;
   end

endmodule

FILE: int8_vector_euclidean_distance.f
sv/ied_pkg.sv
sv/ied_front.sv
sv/ied_queue.sv
sv/ied_sqrt.sv
sv/int8_vector_euclidean_distance.sv
tb/distance_checker.sv
tb/tb_int8_vector_euclidean_distance.sv
